>>> rtl/cda_pkg.sv
// Shared types, codes and calendar helpers for the calendar date adder.
`timescale 1ns / 1ps

package cda_pkg;

   // Operation codes carried in the kind field.
   localparam logic [1:0] KIND_DAYS   = 2'd0;
   localparam logic [1:0] KIND_MONTHS = 2'd1;
   localparam logic [1:0] KIND_YEARS  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // Calendar constants.
   localparam logic [15:0] YEAR_MAX      = 16'hFFFF;
   localparam logic [3:0]  MONTH_JAN     = 4'd1;
   localparam logic [3:0]  MONTH_FEB     = 4'd2;
   localparam logic [3:0]  MONTH_DEC     = 4'd12;
   localparam logic [4:0]  DAY_FIRST     = 5'd1;
   localparam logic [4:0]  DAY_DEC_LAST  = 5'd31;
   localparam logic [8:0]  CYCLE_LAST    = 9'd399;

   // Reciprocals for division by 400 and by 12 through a multiply and shift.
   localparam logic [12:0] RECIP_400 = 13'd5242;
   localparam int          SHIFT_400 = 21;
   localparam logic [15:0] RECIP_12  = 16'd43691;
   localparam int          SHIFT_12  = 19;

   // Input word.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] start_year;
      logic [3:0]  start_month;
      logic [4:0]  start_day;
      logic [15:0] amount;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [15:0] result_year;
      logic [3:0]  result_month;
      logic [4:0]  result_day;
      logic [1:0]  status;
   } rsp_type;

   // What the back end has to do with a classified item.
   typedef enum logic [1:0] {
      CMD_DONE,
      CMD_WALK,
      CMD_SETTLE
   } cmd_op_type;

   // Classified item handed from the front end to the back end.
   typedef struct packed {
      cmd_op_type  op;
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [1:0]  status;
      logic [8:0]  year_mod;
      logic [15:0] amount;
   } cmd_type;

   // Leap year test on the year taken modulo 400.
   function automatic logic is_leap(input logic [8:0] year_mod);
      logic quad;
      logic century;
      quad    = (year_mod[1:0] == 2'b00);
      century = (year_mod == 9'd100) || (year_mod == 9'd200) || (year_mod == 9'd300);
      is_leap = (year_mod == 9'd0) || (quad && !century);
   endfunction

   // Gregorian month length.
   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         MONTH_FEB: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      days_in_month = len;
   endfunction

endpackage

>>> rtl/cda_queue.sv
// Two-entry queue of classified commands between the front and back ends.
`timescale 1ns / 1ps

module cda_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cda_pkg::cmd_type wr_data,
   output logic             full,
   input  logic             pop,
   output cda_pkg::cmd_type rd_data,
   output logic             empty
);
   import cda_pkg::*;

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        do_push;
   logic        do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/cda_front.sv
// Front end: accepts words, checks the date, computes target years and year phases.
`timescale 1ns / 1ps

module cda_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  cda_pkg::req_type req_data,
   output logic             req_full,
   output logic             cmd_push,
   output cda_pkg::cmd_type cmd_data,
   input  logic             cmd_full
);
   import cda_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_REM,
      F_FIX,
      F_CLASS,
      F_PUSH
   } front_state_type;

   front_state_type state_ff;
   logic            pass2_ff;
   logic [1:0]      kind_ff;
   logic [15:0]     year_ff;
   logic [3:0]      month_ff;
   logic [4:0]      day_ff;
   logic [15:0]     amount_ff;
   logic [16:0]     total_ff;
   logic [28:0]     prod400_ff;
   logic [32:0]     prod12_ff;
   logic [9:0]      rem_ff;
   logic [13:0]     quot12_ff;
   logic [8:0]      year_mod_ff;
   cmd_type         cmd_ff;

   logic [7:0]      quot400;
   logic [15:0]     rem_wide;
   logic            leap;
   logic [4:0]      month_len;
   logic            bad_date;
   logic [16:0]     month_rem;
   logic [3:0]      new_month;
   logic [16:0]     target_year;

   // No word is taken while reset is high or an item is in progress.
   assign req_full = reset || (state_ff != F_IDLE);
   assign cmd_push = (state_ff == F_PUSH);
   assign cmd_data = cmd_ff;

   // Year modulo 400 from the reciprocal product, before the final correction.
   assign quot400  = prod400_ff[SHIFT_400 +: 8];
   assign rem_wide = year_ff - ({8'd0, quot400} * 16'd400);

   // Date check and month arithmetic for the classify step.
   assign leap        = is_leap(year_mod_ff);
   assign month_len   = days_in_month(month_ff, leap);
   assign bad_date    = (month_ff == 4'd0) || (month_ff > MONTH_DEC) || (day_ff == 5'd0)
                        || (day_ff > month_len);
   assign month_rem   = total_ff - ({3'd0, quot12_ff} * 17'd12);
   assign new_month   = month_rem[3:0] + 4'd1;
   assign target_year = (kind_ff == KIND_MONTHS) ? ({1'b0, year_ff} + {3'd0, quot12_ff})
                                                 : ({1'b0, year_ff} + {1'b0, amount_ff});

   // Sequencer and its registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pass2_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_push) begin
                  kind_ff   <= req_data.kind;
                  year_ff   <= req_data.start_year;
                  month_ff  <= req_data.start_month;
                  day_ff    <= req_data.start_day;
                  amount_ff <= req_data.amount;
                  total_ff  <= {13'd0, req_data.start_month - 4'd1} + {1'b0, req_data.amount};
                  pass2_ff  <= 1'b0;
                  state_ff  <= F_MUL;
               end
            end
            F_MUL: begin
               prod400_ff <= {13'd0, year_ff} * {16'd0, RECIP_400};
               prod12_ff  <= {16'd0, total_ff} * {17'd0, RECIP_12};
               state_ff   <= F_REM;
            end
            F_REM: begin
               rem_ff    <= rem_wide[9:0];
               quot12_ff <= prod12_ff[SHIFT_12 +: 14];
               state_ff  <= F_FIX;
            end
            F_FIX: begin
               year_mod_ff <= (rem_ff >= 10'd400) ? 9'(rem_ff - 10'd400) : rem_ff[8:0];
               state_ff    <= F_CLASS;
            end
            F_CLASS: begin
               cmd_ff.year     <= year_ff;
               cmd_ff.month    <= month_ff;
               cmd_ff.day      <= day_ff;
               cmd_ff.status   <= STATUS_OK;
               cmd_ff.year_mod <= year_mod_ff;
               cmd_ff.amount   <= amount_ff;
               cmd_ff.op       <= CMD_DONE;
               state_ff        <= F_PUSH;
               if (pass2_ff) begin
                  cmd_ff.op <= CMD_SETTLE;
               end else if (bad_date) begin
                  cmd_ff.year   <= 16'd0;
                  cmd_ff.month  <= MONTH_JAN;
                  cmd_ff.day    <= DAY_FIRST;
                  cmd_ff.status <= STATUS_INVALID;
               end else if (kind_ff == KIND_DAYS) begin
                  cmd_ff.op <= CMD_WALK;
               end else if (kind_ff == KIND_MONTHS || kind_ff == KIND_YEARS) begin
                  if (target_year[16]) begin
                     cmd_ff.year   <= YEAR_MAX;
                     cmd_ff.month  <= MONTH_DEC;
                     cmd_ff.day    <= DAY_DEC_LAST;
                     cmd_ff.status <= STATUS_OVERFLOW;
                  end else begin
                     // Second pass finds the phase of the target year.
                     year_ff  <= target_year[15:0];
                     pass2_ff <= 1'b1;
                     state_ff <= F_MUL;
                     if (kind_ff == KIND_MONTHS) begin
                        month_ff <= new_month;
                     end
                  end
               end
            end
            F_PUSH: begin
               if (!cmd_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/cda_back.sv
// Back end: walks days through months and years, settles clamped days, holds the result.
`timescale 1ns / 1ps

module cda_back (
   input  logic             clock,
   input  logic             reset,
   input  cda_pkg::cmd_type cmd_data,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output cda_pkg::rsp_type rsp_data,
   output logic             rsp_empty,
   input  logic             rsp_pop
);
   import cda_pkg::*;

   typedef enum logic [1:0] {
      B_IDLE,
      B_WALK,
      B_SETTLE,
      B_EMIT
   } back_state_type;

   back_state_type state_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;
   rsp_type        res_ff;
   logic [15:0]    year_ff;
   logic [3:0]     month_ff;
   logic [16:0]    day_ff;
   logic [8:0]     year_mod_ff;

   logic           leap;
   logic [4:0]     month_len;
   logic [16:0]    year_len;
   logic           year_last;
   logic [8:0]     year_mod_next;
   logic           out_take;

   assign cmd_pop   = (state_ff == B_IDLE) && !cmd_empty;
   assign out_take  = (state_ff == B_EMIT) && (!rsp_valid_ff || rsp_pop);
   assign rsp_data  = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;

   // Calendar facts about the current position.
   assign leap          = is_leap(year_mod_ff);
   assign month_len     = days_in_month(month_ff, leap);
   assign year_len      = leap ? 17'd366 : 17'd365;
   assign year_last     = (year_ff == YEAR_MAX);
   assign year_mod_next = (year_mod_ff == CYCLE_LAST) ? 9'd0 : year_mod_ff + 9'd1;

   // Sequencer: one month, or one whole year from January, per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         unique case (state_ff)
            B_IDLE: begin
               if (!cmd_empty) begin
                  year_ff     <= cmd_data.year;
                  month_ff    <= cmd_data.month;
                  year_mod_ff <= cmd_data.year_mod;
                  res_ff      <= '{cmd_data.year, cmd_data.month, cmd_data.day, cmd_data.status};
                  unique case (cmd_data.op)
                     CMD_WALK: begin
                        day_ff   <= {12'd0, cmd_data.day} + {1'b0, cmd_data.amount};
                        state_ff <= B_WALK;
                     end
                     CMD_SETTLE: begin
                        day_ff   <= {12'd0, cmd_data.day};
                        state_ff <= B_SETTLE;
                     end
                     default: begin
                        state_ff <= B_EMIT;
                     end
                  endcase
               end
            end
            B_WALK: begin
               priority if (month_ff == MONTH_JAN && day_ff > year_len) begin
                  day_ff <= day_ff - year_len;
                  if (year_last) begin
                     res_ff   <= '{YEAR_MAX, MONTH_DEC, DAY_DEC_LAST, STATUS_OVERFLOW};
                     state_ff <= B_EMIT;
                  end else begin
                     year_ff     <= year_ff + 16'd1;
                     year_mod_ff <= year_mod_next;
                  end
               end else if (day_ff > {12'd0, month_len}) begin
                  day_ff <= day_ff - {12'd0, month_len};
                  if (month_ff == MONTH_DEC) begin
                     month_ff <= MONTH_JAN;
                     if (year_last) begin
                        res_ff   <= '{YEAR_MAX, MONTH_DEC, DAY_DEC_LAST, STATUS_OVERFLOW};
                        state_ff <= B_EMIT;
                     end else begin
                        year_ff     <= year_ff + 16'd1;
                        year_mod_ff <= year_mod_next;
                     end
                  end else begin
                     month_ff <= month_ff + 4'd1;
                  end
               end else begin
                  res_ff   <= '{year_ff, month_ff, day_ff[4:0], STATUS_OK};
                  state_ff <= B_EMIT;
               end
            end
            B_SETTLE: begin
               state_ff <= B_EMIT;
               if (day_ff > {12'd0, month_len}) begin
                  if (month_ff != MONTH_DEC) begin
                     res_ff <= '{year_ff, month_ff + 4'd1, DAY_FIRST, STATUS_OK};
                  end else if (year_last) begin
                     res_ff <= '{YEAR_MAX, MONTH_DEC, DAY_DEC_LAST, STATUS_OVERFLOW};
                  end else begin
                     res_ff <= '{year_ff + 16'd1, MONTH_JAN, DAY_FIRST, STATUS_OK};
                  end
               end
            end
            B_EMIT: begin
               if (out_take) begin
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   // Output register: holds the oldest result until it is popped.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_ff <= res_ff;
      end
   end

endmodule

>>> rtl/calendar_date_adder.sv
// Top level of the calendar date adder: front end, command queue and back end.
// A word is taken when req_push is high and req_full is low; the front end then checks
// the date (the year phase modulo 400 comes from a reciprocal multiply) and, for month
// and year additions, makes a second pass to find the target year's phase. For day
// additions the back end steps one whole year per cycle from January and one month per
// cycle otherwise. That day walk sets the sustained rate. The two-entry queue lets the
// front end classify the next word while the back end is walking, and a finished
// result waits in the output register until rsp_pop takes it.
`timescale 1ns / 1ps

module calendar_date_adder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  cda_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cda_pkg::rsp_type rsp_data
);
   import cda_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    front_push;
   logic    queue_full;
   logic    queue_empty;
   logic    back_pop;

   cda_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (front_push),
      .cmd_data (front_cmd),
      .cmd_full (queue_full)
   );

   cda_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .wr_data (front_cmd),
      .full    (queue_full),
      .pop     (back_pop),
      .rd_data (queue_cmd),
      .empty   (queue_empty)
   );

   cda_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (queue_cmd),
      .cmd_empty (queue_empty),
      .cmd_pop   (back_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

>>> rtl/cda_checker.sv
// Port-level checks for the calendar date adder, bound to the top level.
`timescale 1ns / 1ps

module cda_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input cda_pkg::rsp_type rsp_data
);
   import cda_pkg::*;

   // No result may be waiting right after reset.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   // A waiting word that is not popped stays unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   // Status only takes its defined codes.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_INVALID
                      || rsp_data.status == STATUS_OVERFLOW))
      else $error("undefined status code");

   // Overflow saturates to the last day of the last year.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == STATUS_OVERFLOW) |->
      (rsp_data.result_year == YEAR_MAX && rsp_data.result_month == MONTH_DEC
       && rsp_data.result_day == DAY_DEC_LAST))
      else $error("overflow result not saturated");

   // A successful result is a real calendar position.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == STATUS_OK) |->
      (rsp_data.result_month != 4'd0 && rsp_data.result_month <= MONTH_DEC
       && rsp_data.result_day != 5'd0))
      else $error("result date out of range");

endmodule

bind calendar_date_adder cda_checker u_cda_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for the calendar date adder: directed, pressure and random words.
`timescale 1ns / 1ps

module tb_top;
   import cda_pkg::*;

   // Kind code that the block leaves without an operation.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Largest year as a full-width number for the date arithmetic.
   localparam int unsigned YEAR_TOP = 32'(YEAR_MAX);

   localparam int RANDOM_WORDS   = 1250;
   localparam int PRESSURE_WORDS = 24;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int END_WAIT       = 300;
   localparam int REPORT_CAP     = 40;

   // One accepted request word together with the date sum it must produce.
   typedef struct packed {
      req_type word;
      rsp_type sum;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   pending_type pending_sums[$];
   pending_type oldest;
   int          mismatch_count = 0;
   int          idle_cycles = 0;

   // Sender burst control.
   bit sender_bursty = 1'b1;
   int burst_left = 0;

   // Receiver stall control.
   bit hold_request = 1'b0;
   int pop_hold_left = 0;
   int pop_mode = 0;
   int pop_phase = 0;

   calendar_date_adder dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Free-running clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gregorian leap year rule.
   function automatic bit leap_year(input int unsigned year);
      return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
   endfunction

   function automatic int unsigned month_length(input int unsigned year, input int unsigned month);
      case (month)
         2: begin
            return leap_year(year) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   function automatic rsp_type date_word(input int unsigned year, input int unsigned month,
                                         input int unsigned day, input logic [1:0] status);
      rsp_type r;
      r.result_year  = year[15:0];
      r.result_month = month[3:0];
      r.result_day   = day[4:0];
      r.status       = status;
      return r;
   endfunction

   // Computes the date that the block must return for one request word.
   function automatic rsp_type add_to_date(input req_type w);
      int unsigned year;
      int unsigned month;
      int unsigned day;
      int unsigned len;
      int unsigned total;
      rsp_type     saturated;
      year      = {16'd0, w.start_year};
      month     = {28'd0, w.start_month};
      day       = {27'd0, w.start_day};
      saturated = rsp_type'{YEAR_MAX, MONTH_DEC, DAY_DEC_LAST, STATUS_OVERFLOW};

      // The date check comes before anything else.
      if (month < 1 || month > 12 || day < 1 || day > month_length(year, month))
         return rsp_type'{16'd0, MONTH_JAN, DAY_FIRST, STATUS_INVALID};

      case (w.kind)
         KIND_DAYS: begin
            day = day + {16'd0, w.amount};
            len = month_length(year, month);
            while (day > len) begin
               day   = day - len;
               month = month + 1;
               if (month > 12) begin
                  month = 1;
                  year  = year + 1;
                  if (year > YEAR_TOP)
                     return saturated;
               end
               len = month_length(year, month);
            end
         end
         KIND_MONTHS, KIND_YEARS: begin
            if (w.kind == KIND_MONTHS) begin
               total = (month - 1) + {16'd0, w.amount};
               year  = year + total / 12;
               month = total % 12 + 1;
            end else begin
               year = year + {16'd0, w.amount};
            end
            if (year > YEAR_TOP)
               return saturated;
            // A day past the month's end moves to the first of the next month.
            if (day > month_length(year, month)) begin
               day   = 1;
               month = month + 1;
               if (month > 12) begin
                  month = 1;
                  year  = year + 1;
                  if (year > YEAR_TOP)
                     return saturated;
               end
            end
         end
         default: begin
         end
      endcase
      return date_word(year, month, day, STATUS_OK);
   endfunction

   task automatic report_mismatch(input string what, input req_type w,
                                  input int unsigned got, input int unsigned want);
      if (mismatch_count < REPORT_CAP)
         $display("%0t mismatch %s: kind %0d date %0d-%0d-%0d amount %0d got %0d want %0d",
                  $time, what, w.kind, w.start_year, w.start_month, w.start_day, w.amount,
                  got, want);
      mismatch_count++;
   endtask

   // Offers one word, waits for it to be taken and records its expected sum.
   task automatic send_word(input req_type w);
      int gap;
      pending_type p;
      req_push <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      p.word = w;
      p.sum  = add_to_date(w);
      pending_sums.push_back(p);
      if (sender_bursty) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : int'($urandom_range(0, 30));
            gap = int'($urandom_range(1, 12));
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_date(input logic [1:0] kind, input logic [15:0] year,
                            input logic [3:0] month, input logic [4:0] day,
                            input logic [15:0] amount);
      req_type w;
      w.kind        = kind;
      w.start_year  = year;
      w.start_month = month;
      w.start_day   = day;
      w.amount      = amount;
      send_word(w);
   endtask

   // Stops offering words until every expected sum has come back.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_sums.size() != 0)
         @(posedge clock);
   endtask

   // Builds a random word, mostly a valid date with an amount of varied size.
   function automatic req_type random_date_word();
      req_type     w;
      int unsigned sel;
      int unsigned len;
      sel = $urandom_range(0, 19);
      if (sel < 7)
         w.kind = KIND_DAYS;
      else if (sel < 13)
         w.kind = KIND_MONTHS;
      else if (sel < 19)
         w.kind = KIND_YEARS;
      else
         w.kind = KIND_UNUSED;

      case ($urandom_range(0, 5))
         0: w.start_year = 16'($urandom_range(0, 3));
         1: w.start_year = 16'($urandom_range(65500, 65535));
         2: w.start_year = 16'($urandom_range(0, 655) * 100);
         default: w.start_year = 16'($urandom_range(0, 65535));
      endcase

      if ($urandom_range(0, 15) == 0)
         w.start_month = 4'($urandom_range(0, 15));
      else
         w.start_month = 4'($urandom_range(1, 12));

      len = month_length({16'd0, w.start_year}, {28'd0, w.start_month});
      case ($urandom_range(0, 15))
         0: w.start_day = 5'($urandom_range(0, 31));
         1, 2, 3: w.start_day = 5'(len);
         4: w.start_day = 5'(len - 1);
         default: w.start_day = 5'($urandom_range(1, len));
      endcase

      sel = $urandom_range(0, 9);
      if (w.kind == KIND_DAYS) begin
         if (sel < 5)
            w.amount = 16'($urandom_range(0, 60));
         else if (sel < 8)
            w.amount = 16'($urandom_range(0, 2000));
         else if (sel < 9)
            w.amount = 16'($urandom_range(0, 65535));
         else
            w.amount = 16'(65535 - $urandom_range(0, 15));
      end else begin
         if (sel < 6)
            w.amount = 16'($urandom_range(0, 30));
         else if (sel < 9)
            w.amount = 16'($urandom_range(0, 65535));
         else
            w.amount = 16'((YEAR_TOP - {16'd0, w.start_year}) + $urandom_range(0, 1));
      end
      return w;
   endfunction

   task automatic test_invalid_dates();
      send_date(KIND_DAYS, 2023, 0, 10, 5);
      send_date(KIND_MONTHS, 2023, 13, 1, 1);
      send_date(KIND_YEARS, 2023, 15, 31, 0);
      send_date(KIND_DAYS, 2023, 6, 0, 1);
      send_date(KIND_DAYS, 1900, 2, 29, 1);
      send_date(KIND_MONTHS, 2023, 4, 31, 1);
   endtask

   task automatic test_day_addition();
      send_date(KIND_DAYS, 2023, 12, 31, 1);
      send_date(KIND_DAYS, 2000, 2, 28, 1);
      send_date(KIND_DAYS, 1900, 2, 28, 1);
      send_date(KIND_DAYS, 0, 2, 28, 1);
      send_date(KIND_DAYS, 0, 1, 1, 65535);
      send_date(KIND_DAYS, 65535, 12, 31, 1);
      send_date(KIND_DAYS, 2024, 5, 17, 0);
   endtask

   task automatic test_month_addition();
      send_date(KIND_MONTHS, 2023, 1, 31, 1);
      send_date(KIND_MONTHS, 2023, 12, 15, 1);
      send_date(KIND_MONTHS, 0, 1, 1, 65535);
      send_date(KIND_MONTHS, 65535, 12, 1, 1);
      send_date(KIND_MONTHS, 2024, 3, 31, 11);
   endtask

   task automatic test_year_addition();
      send_date(KIND_YEARS, 2000, 2, 29, 1);
      send_date(KIND_YEARS, 2000, 2, 29, 400);
      send_date(KIND_YEARS, 1, 1, 1, 65535);
      send_date(KIND_YEARS, 0, 6, 30, 65535);
   endtask

   task automatic test_unused_kind();
      send_date(KIND_UNUSED, 1999, 7, 4, 12345);
      send_date(KIND_UNUSED, 2023, 2, 30, 1);
   endtask

   // The receiver holds off while words keep coming, so the block fills and stalls its input.
   task automatic test_fill_and_stall();
      hold_request  = 1'b1;
      sender_bursty = 1'b0;
      repeat (PRESSURE_WORDS) begin
         send_date(($urandom_range(0, 1) != 0) ? KIND_YEARS : KIND_MONTHS,
                   16'($urandom_range(0, 65535)), 4'($urandom_range(1, 12)),
                   5'($urandom_range(1, 28)), 16'($urandom_range(0, 30)));
      end
      sender_bursty = 1'b1;
      wait_drained();
   endtask

   task automatic test_random_dates();
      repeat (RANDOM_WORDS) send_word(random_date_word());
   endtask

   // Receiver: switches between stall patterns and serves long hold-off requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_request || pop_hold_left > 0) begin
         if (hold_request) begin
            pop_hold_left = HOLD_CYCLES;
            hold_request  = 1'b0;
         end
         pop_hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         pop_phase++;
         if (pop_phase % 200 == 0)
            pop_mode = int'($urandom_range(0, 3));
         case (pop_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= 1'($urandom_range(0, 1));
            2: rsp_pop <= (pop_phase % 4 == 0);
            default: rsp_pop <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // Compares each popped word with the oldest expected sum.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_sums.size() == 0) begin
            report_mismatch("unexpected result", '0, 32'(rsp_data), 0);
         end else begin
            oldest = pending_sums.pop_front();
            if (rsp_data.result_year !== oldest.sum.result_year)
               report_mismatch("year", oldest.word, 32'(rsp_data.result_year),
                               32'(oldest.sum.result_year));
            if (rsp_data.result_month !== oldest.sum.result_month)
               report_mismatch("month", oldest.word, 32'(rsp_data.result_month),
                               32'(oldest.sum.result_month));
            if (rsp_data.result_day !== oldest.sum.result_day)
               report_mismatch("day", oldest.word, 32'(rsp_data.result_day),
                               32'(oldest.sum.result_day));
            if (rsp_data.status !== oldest.sum.status)
               report_mismatch("status", oldest.word, 32'(rsp_data.status),
                               32'(oldest.sum.status));
         end
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_invalid_dates();
      test_day_addition();
      test_month_addition();
      test_year_addition();
      test_unused_kind();
      test_fill_and_stall();
      test_random_dates();

      // Let the last words drain, then watch for stray results.
      wait_drained();
      repeat (END_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> filelist.f
rtl/cda_pkg.sv
rtl/cda_queue.sv
rtl/cda_front.sv
rtl/cda_back.sv
rtl/calendar_date_adder.sv
rtl/cda_checker.sv
sim/tb_top.sv
